FILE: rtl/core/qgt_pkg.sv
// ----------------------------------------------------------------------------
// qgt_pkg: shared definitions for the gait trajectory generator
// Sizes, operand types and the divider request word used across the core.
// ----------------------------------------------------------------------------
package qgt_pkg;

    // legs, phase accumulator width and sine table depth
    localparam int LEG_COUNT  = 4;
    localparam int PHASE_BITS = 16;
    localparam int SINE_DEPTH = 256;

    localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
    localparam int LEG_W      = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;

    // shared multiplier operands and product
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    // shared divider: quotient bits, divisor bits, step counter bits
    localparam int QUO_W  = 16;
    localparam int DEN_W  = 17;
    localparam int STEP_W = $clog2(QUO_W);

    typedef logic signed [MUL_W-1:0]  mul_op_t;
    typedef logic signed [PROD_W-1:0] mul_prod_t;
    typedef logic [15:0]              sine_t;

    // divider launch request
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps_m1;
    } div_req_t;

endpackage

FILE: rtl/core/qgt_mult.sv
// ----------------------------------------------------------------------------
// qgt_mult: shared signed multiplier
// One registered signed product per cycle, reused by every multiply step.
// ----------------------------------------------------------------------------
module qgt_mult import qgt_pkg::*; (
    input  logic      aclk,
    input  mul_op_t   op_a,
    input  mul_op_t   op_b,
    output mul_prod_t prod
);

    mul_prod_t prod_reg;
    mul_prod_t prod_next;

    // full-width signed product
    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/core/qgt_div.sv
// ----------------------------------------------------------------------------
// qgt_div: shared restoring divider
// One quotient bit per cycle; the caller preloads a partial remainder that is
// below the divisor and the low numerator bits to shift in.
// ----------------------------------------------------------------------------
module qgt_div import qgt_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    input  logic [DEN_W-1:0] rem_init,
    input  logic [QUO_W-1:0] low_init,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [QUO_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  low_reg, low_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;

    // one shift-compare-subtract step
    always_comb begin
        trial     = {rem_reg, low_reg[QUO_W-1]};
        diff      = trial - {1'b0, den};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps_m1;
            rem_next  = rem_init;
            low_next  = low_init;
            quo_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den}) begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            low_next = {low_reg[QUO_W-2:0], 1'b0};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/qgt_sine_rom.sv
// ----------------------------------------------------------------------------
// qgt_sine_rom: half-wave sine table
// Entry i approximates sin(pi*i/D) in Q1.15 using the rational formula
// 16p*32768 / (5D^2 - 4p) with p = i*(D-i), built at elaboration.
// ----------------------------------------------------------------------------
module qgt_sine_rom import qgt_pkg::*; (
    input  logic [SINE_IDX_W-1:0] idx,
    output sine_t                 sine
);

    localparam int ROWS = 2 ** SINE_IDX_W;

    sine_t rom [ROWS];

    // constant entries, indexes past the depth repeat the last entry
    for (genvar gi = 0; gi < ROWS; gi++) begin : g_row
        localparam longint DEP = SINE_DEPTH;
        localparam longint IX  = (gi < SINE_DEPTH) ? gi : SINE_DEPTH - 1;
        localparam longint PRD = IX * (DEP - IX);
        localparam longint VAL = (16 * PRD * 32768) / (5 * DEP * DEP - 4 * PRD);
        assign rom[gi] = sine_t'(VAL);
    end

    assign sine = rom[idx];

endmodule

FILE: rtl/core/quadruped_gait_trajectory.sv
// ----------------------------------------------------------------------------
// quadruped_gait_trajectory: per-tick foot targets for a four-legged gait
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    s_phase_step
//   m_       out        m_valid / m_ready    m_leg, m_foot_x, m_foot_y,
//                                            m_grounded, m_last_leg
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One input word yields one result word per leg, legs in order. Each leg runs
// through a small sequencer around one multiplier and one divider:
// a stance leg divides once (not at all when mid_phase is zero), a swing leg
// divides twice, and the input word is taken in the idle step before the legs.
// Synchronous active-low reset restores the register defaults and clears the
// accumulator. A stalled output holds the sequencer at its emit step; the
// last result of a tick may wait while the next input word is taken.
// ----------------------------------------------------------------------------
module quadruped_gait_trajectory import qgt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_phase_step,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_leg,
    output logic signed [15:0] m_foot_x,
    output logic signed [15:0] m_foot_y,
    output logic               m_grounded,
    output logic               m_last_leg,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    typedef enum logic [2:0] {
        REG_MID_PHASE   = 3'd0,
        REG_HALF_STRIDE = 3'd1,
        REG_LIFT_HEIGHT = 3'd2,
        REG_X_BIAS      = 3'd3,
        REG_X_SCALE     = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEG,
        ST_MUL_X,
        ST_DIV_X,
        ST_WAIT_X,
        ST_MUL_IDX,
        ST_DIV_IDX,
        ST_WAIT_IDX,
        ST_SINE,
        ST_MUL_Y,
        ST_MUL_S,
        ST_EMIT
    } state_t;

    localparam logic [15:0] WALK_OFS [4] = '{16'd49152, 16'd32768, 16'd0, 16'd16384};
    localparam logic [15:0] TROT_OFS [4] = '{16'd32768, 16'd32768, 16'd0, 16'd0};

    // sequencer and tick state
    state_t                 state_reg, state_next;
    logic [PHASE_BITS-1:0]  accum_reg, accum_next;
    logic [LEG_W-1:0]       leg_reg, leg_next;

    // configuration registers
    logic [15:0]            mid_reg, mid_next;
    logic [14:0]            stride_reg, stride_next;
    logic [14:0]            lift_reg, lift_next;
    logic signed [15:0]     bias_reg, bias_next;
    logic [15:0]            scale_reg, scale_next;

    // per-leg working registers
    logic [15:0]            t_reg, t_next;
    logic [15:0]            d_reg, d_next;
    logic                   ground_reg, ground_next;
    logic signed [15:0]     x_reg, x_next;
    logic [15:0]            y_reg, y_next;
    sine_t                  sine_reg, sine_next;

    // output word
    logic                   m_valid_reg, m_valid_next;
    logic [1:0]             m_leg_reg, m_leg_next;
    logic signed [15:0]     m_x_reg, m_x_next;
    logic [15:0]            m_y_reg, m_y_next;
    logic                   m_gnd_reg, m_gnd_next;
    logic                   m_last_reg, m_last_next;

    // datapath wires
    logic [PHASE_BITS-1:0]  step_aligned;
    logic [15:0]            a16;
    logic [LEG_W+1:0]       leg_ext;
    logic [1:0]             leg_mod;
    logic [15:0]            offset;
    logic [15:0]            t_now;
    logic [DEN_W-1:0]       n_swing;
    logic                   last_leg;
    logic [16:0]            s17;
    logic [16:0]            q17;
    logic [16:0]            x17;
    logic signed [20:0]     x_fin;
    logic signed [15:0]     x_sat;

    mul_op_t                mul_a, mul_b;
    mul_prod_t              prod;
    div_req_t               div_req;
    logic [DEN_W-1:0]       div_rem_init;
    logic [QUO_W-1:0]       div_low_init;
    logic [DEN_W-1:0]       div_den;
    logic                   div_busy;
    logic [QUO_W-1:0]       div_quo;
    sine_t                  sine_val;

    // phase step alignment and Q0.16 view of the accumulator
    if (PHASE_BITS >= 16) begin : g_phase_wide
        assign step_aligned = PHASE_BITS'(s_phase_step) << (PHASE_BITS - 16);
        assign a16          = accum_reg[PHASE_BITS-1 -: 16];
    end else begin : g_phase_narrow
        assign step_aligned = s_phase_step[15 -: PHASE_BITS];
        assign a16          = 16'(accum_reg) << (16 - PHASE_BITS);
    end

    // leg phase and gait offsets
    assign leg_ext  = {2'b00, leg_reg};
    assign leg_mod  = leg_ext[1:0];
    assign offset   = (mid_reg > 16'd32768) ? WALK_OFS[leg_mod] : TROT_OFS[leg_mod];
    assign t_now    = offset - a16;
    assign n_swing  = 17'h1_0000 - {1'b0, mid_reg};
    assign last_leg = (leg_reg == LEG_W'(LEG_COUNT - 1));

    // stride position from the divider quotient
    assign s17 = {2'b00, stride_reg};
    assign q17 = {1'b0, div_quo};
    assign x17 = ground_reg ? (q17 - s17) : (s17 - q17);

    // scaled x minus bias, saturated
    assign x_fin = 21'(signed'(prod[33:14])) - 21'(bias_reg);
    always_comb begin
        if (x_fin > 21'sd32767) begin
            x_sat = 16'sh7FFF;
        end else if (x_fin < -21'sd32768) begin
            x_sat = -16'sh8000;
        end else begin
            x_sat = x_fin[15:0];
        end
    end

    // shared multiplier operand select, scaled x held while the output stalls
    always_comb begin
        unique case (state_reg) inside
            ST_MUL_X: begin
                mul_a = {1'b0, stride_reg, 1'b0};
                mul_b = ground_reg ? {1'b0, t_reg} : {1'b0, d_reg};
            end
            ST_MUL_IDX: begin
                mul_a = {1'b0, d_reg};
                mul_b = mul_op_t'(SINE_DEPTH);
            end
            ST_MUL_Y: begin
                mul_a = {2'b00, lift_reg};
                mul_b = {1'b0, sine_reg};
            end
            ST_MUL_S, ST_EMIT: begin
                mul_a = {x_reg[15], x_reg};
                mul_b = {1'b0, scale_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared divider operand select
    always_comb begin
        div_den = ground_reg ? {1'b0, mid_reg} : n_swing;
        if (state_reg == ST_DIV_IDX) begin
            div_rem_init = prod[SINE_IDX_W+DEN_W-1:SINE_IDX_W];
            div_low_init = QUO_W'(prod[SINE_IDX_W-1:0]) << (QUO_W - SINE_IDX_W);
        end else begin
            div_rem_init = {1'b0, prod[31:16]};
            div_low_init = prod[15:0];
        end
    end

    qgt_mult u_mult (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    qgt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .rem_init (div_rem_init),
        .low_init (div_low_init),
        .den      (div_den),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    qgt_sine_rom u_sine (
        .idx  (div_quo[SINE_IDX_W-1:0]),
        .sine (sine_val)
    );

    // sequencer and register next values
    always_comb begin
        state_next       = state_reg;
        accum_next       = accum_reg;
        leg_next         = leg_reg;
        mid_next         = mid_reg;
        stride_next      = stride_reg;
        lift_next        = lift_reg;
        bias_next        = bias_reg;
        scale_next       = scale_reg;
        t_next           = t_reg;
        d_next           = d_reg;
        ground_next      = ground_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        sine_next        = sine_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_leg_next       = m_leg_reg;
        m_x_next         = m_x_reg;
        m_y_next         = m_y_reg;
        m_gnd_next       = m_gnd_reg;
        m_last_next      = m_last_reg;
        div_req.start    = 1'b0;
        div_req.steps_m1 = STEP_W'(QUO_W - 1);

        // configuration writes
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MID_PHASE:   mid_next    = cfg_data;
                REG_HALF_STRIDE: stride_next = cfg_data[14:0];
                REG_LIFT_HEIGHT: lift_next   = cfg_data[14:0];
                REG_X_BIAS:      bias_next   = signed'(cfg_data);
                REG_X_SCALE:     scale_next  = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    accum_next = accum_reg + step_aligned;
                    leg_next   = '0;
                    state_next = ST_LEG;
                end
            end
            ST_LEG: begin
                t_next      = t_now;
                d_next      = t_now - mid_reg;
                ground_next = (t_now <= mid_reg);
                y_next      = '0;
                state_next  = ST_MUL_X;
            end
            ST_MUL_X: begin
                state_next = ST_DIV_X;
            end
            ST_DIV_X: begin
                // zero stance length: only t equal to zero lands here
                if (ground_reg && (mid_reg == '0)) begin
                    x_next     = -signed'({1'b0, stride_reg});
                    state_next = ST_MUL_S;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.steps_m1 = STEP_W'(QUO_W - 1);
                    state_next       = ST_WAIT_X;
                end
            end
            ST_WAIT_X: begin
                if (!div_busy) begin
                    x_next     = x17[15:0];
                    state_next = ground_reg ? ST_MUL_S : ST_MUL_IDX;
                end
            end
            ST_MUL_IDX: begin
                state_next = ST_DIV_IDX;
            end
            ST_DIV_IDX: begin
                div_req.start    = 1'b1;
                div_req.steps_m1 = STEP_W'(SINE_IDX_W - 1);
                state_next       = ST_WAIT_IDX;
            end
            ST_WAIT_IDX: begin
                if (!div_busy) begin
                    state_next = ST_SINE;
                end
            end
            ST_SINE: begin
                sine_next  = sine_val;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                state_next = ST_MUL_S;
            end
            ST_MUL_S: begin
                if (!ground_reg) begin
                    y_next = prod[30:15];
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_leg_next   = leg_mod;
                    m_x_next     = x_sat;
                    m_y_next     = y_reg;
                    m_gnd_next   = ground_reg;
                    m_last_next  = last_leg;
                    if (last_leg) begin
                        state_next = ST_IDLE;
                    end else begin
                        leg_next   = leg_reg + 1'b1;
                        state_next = ST_LEG;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state, configuration, working and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            accum_reg   <= '0;
            leg_reg     <= '0;
            mid_reg     <= 16'd52429;
            stride_reg  <= 15'd1229;
            lift_reg    <= 15'd410;
            bias_reg    <= 16'sd451;
            scale_reg   <= 16'd16384;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            accum_reg   <= accum_next;
            leg_reg     <= leg_next;
            mid_reg     <= mid_next;
            stride_reg  <= stride_next;
            lift_reg    <= lift_next;
            bias_reg    <= bias_next;
            scale_reg   <= scale_next;
            m_valid_reg <= m_valid_next;
            t_reg       <= t_next;
            d_reg       <= d_next;
            ground_reg  <= ground_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            sine_reg    <= sine_next;
            m_leg_reg   <= m_leg_next;
            m_x_reg     <= m_x_next;
            m_y_reg     <= m_y_next;
            m_gnd_reg   <= m_gnd_next;
            m_last_reg  <= m_last_next;
        end
    end

    // ports
    assign s_ready    = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_leg      = m_leg_reg;
    assign m_foot_x   = m_x_reg;
    assign m_foot_y   = signed'(m_y_reg);
    assign m_grounded = m_gnd_reg;
    assign m_last_leg = m_last_reg;

endmodule
